// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the wheel speed controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WSPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define WSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wspp_pkg.sv =====
// Constants, types and helpers for the wheel speed PID / PWM controller.
package wspp_pkg;

  // Encoder count window and center
  localparam logic [15:0] CNT_HIGH   = 16'h8400;
  localparam logic [15:0] CNT_LOW    = 16'h7C00;
  localparam logic [15:0] CNT_CENTER = 16'h8000;

  localparam logic [6:0]         SPEED_LIMIT = 7'd127;
  localparam logic signed [7:0]  ERR_OVF     = 8'sd119;
  localparam logic signed [9:0]  ERR_MAX     = 10'sd127;
  localparam logic signed [9:0]  ERR_MIN     = -10'sd128;
  localparam logic [9:0]         P_LIMIT     = 10'd900;
  localparam logic [6:0]         D_LIMIT     = 7'd127;
  localparam logic signed [15:0] I_LIMIT     = 16'sd500;
  localparam logic [9:0]         DUTY_FULL   = 10'd1020;

  // (2^17 + 1) / 3: exact floor(x / 3) for any 16-bit x after >> 17
  localparam logic [16:0] DIV3_RECIP = 17'd43691;

  localparam logic [7:0] P_GAIN_RST = 8'd25;
  localparam logic [7:0] I_GAIN_RST = 8'd4;
  localparam logic [7:0] D_GAIN_RST = 8'd1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    REG_P_GAIN       = 2'd0,
    REG_I_GAIN       = 2'd1,
    REG_D_GAIN       = 2'd2,
    REG_SPEED_TARGET = 2'd3
  } cfg_idx_t;

  // Result beat, highest field first
  typedef struct packed {
    logic              pad;
    logic signed [7:0] measured_speed;
    logic signed [7:0] speed_error;
    logic signed [11:0] drive_sum;
    logic              drive_forward;
    logic [9:0]        pwm_duty;
  } out_beat_t;

  // floor(x / 3) by reciprocal multiply
  function automatic logic [14:0] div3(input logic [15:0] x);
    logic [32:0] prod;
    prod = {17'b0, x} * {16'b0, DIV3_RECIP};
    return prod[31:17];
  endfunction

endpackage

// ===== rtl/wheel_speed_pid_pwm.sv =====
// Wheel speed PID controller: encoder count in, PWM duty and drive terms out.
// Each input beat is one control tick carrying the encoder count (0x8000 means no motion);
// the block clamps it, scales it to a saturated speed, forms the error against
// speed_target, builds clamped P, D and I terms (gain product divided by three, toward
// zero) and returns one result beat with duty, direction, drive sum, error and speed.
// It sustains one beat per clock cycle while the result side keeps up; a result passes
// through three register stages: input register, gain-product register and result
// register. Backpressure on the result side stalls the stages in order, so the input
// side keeps taking beats while bubbles remain.
// Gains and target are to be written by the user through the cfg port only while no tick
// is in flight; the block does not enforce this. Writes take effect at once.
`include "assert_macros.svh"

module wheel_speed_pid_pwm
  import wspp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [7:0]            cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] position_count
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [9:0] pwm_duty, [10] drive_forward,
                                            // [22:11] drive_sum, [30:23] speed_error,
                                            // [38:31] measured_speed, [39] zero
);

  // Configuration registers
  logic [7:0]        p_gain_r, i_gain_r, d_gain_r;
  logic signed [7:0] speed_target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r       <= P_GAIN_RST;
      i_gain_r       <= I_GAIN_RST;
      d_gain_r       <= D_GAIN_RST;
      speed_target_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_P_GAIN:       p_gain_r       <= cfg_wdata;
        REG_I_GAIN:       i_gain_r       <= cfg_wdata;
        REG_D_GAIN:       d_gain_r       <= cfg_wdata;
        REG_SPEED_TARGET: speed_target_r <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage handshake: each stage advances when the next one is free.
  // ------------------------------------------------------------------
  logic s0_v_r, s1_v_r, out_v_r;
  logic out_rdy, s1_rdy, s0_rdy, s0_adv, s1_adv;

  assign out_rdy   = !out_v_r || out_tready;
  assign s1_rdy    = !s1_v_r || out_rdy;
  assign s0_rdy    = !s0_v_r || s1_rdy;
  assign s0_adv    = s0_v_r && s1_rdy;
  assign s1_adv    = s1_v_r && out_rdy;
  assign in_tready = s0_rdy;

  // ------------------------------------------------------------------
  // Stage 0: input register
  // ------------------------------------------------------------------
  logic [15:0] s0_cnt_r;

  // ------------------------------------------------------------------
  // Stage 0 -> 1 logic: speed, error, error change and gain products
  // ------------------------------------------------------------------
  logic [15:0]       cnt_c;
  logic [10:0]       diff_c;
  logic              diff_neg;
  logic [9:0]        diff_mag;
  logic [7:0]        spd_q;
  logic [6:0]        spd_sat;
  logic signed [7:0] spd_c;
  logic signed [9:0] err_raw;
  logic signed [7:0] err_c;
  logic              err_neg;
  logic [7:0]        err_abs;
  logic signed [8:0] derr_c;
  logic              derr_neg;
  logic [7:0]        derr_abs;
  logic signed [7:0] prev_err_r;

  always_comb begin
    // Clamp the count into the open window around the center
    cnt_c = s0_cnt_r;
    if (s0_cnt_r >= CNT_HIGH) begin
      cnt_c = CNT_HIGH - 16'd1;
    end else if (s0_cnt_r <= CNT_LOW) begin
      cnt_c = CNT_LOW + 16'd1;
    end

    // Offset fits 11 bits signed; divide the magnitude by four (toward zero)
    diff_c   = 11'(cnt_c - CNT_CENTER);
    diff_neg = diff_c[10];
    diff_mag = diff_neg ? 10'(-diff_c) : diff_c[9:0];
    spd_q    = diff_mag[9:2];
    spd_sat  = (spd_q > {1'b0, SPEED_LIMIT}) ? SPEED_LIMIT : spd_q[6:0];
    spd_c    = diff_neg ? -signed'({1'b0, spd_sat}) : signed'({1'b0, spd_sat});

    // Error with overflow folded to +-119 by its true sign
    err_raw = 10'(spd_c) - 10'(speed_target_r);
    if (err_raw > ERR_MAX) begin
      err_c = ERR_OVF;
    end else if (err_raw < ERR_MIN) begin
      err_c = -ERR_OVF;
    end else begin
      err_c = err_raw[7:0];
    end

    err_neg  = err_c[7];
    err_abs  = err_neg ? 8'(-err_c) : err_c;
    derr_c   = 9'(err_c) - 9'(prev_err_r);
    derr_neg = derr_c[8];
    derr_abs = derr_neg ? 8'(-derr_c) : derr_c[7:0];
  end

  // ------------------------------------------------------------------
  // Stage 1: product register
  // ------------------------------------------------------------------
  logic [15:0]       s1_pm_r, s1_im_r, s1_dm_r;
  logic              s1_eneg_r, s1_dneg_r, s1_clr_r;
  logic signed [7:0] s1_err_r, s1_spd_r;

  // ------------------------------------------------------------------
  // Stage 1 -> out logic: divide by three, clamp, integrate, sum
  // ------------------------------------------------------------------
  logic [14:0]        pq, dq, iq;
  logic [9:0]         p_mag;
  logic [6:0]         d_mag;
  logic signed [11:0] p_term, d_term;
  logic signed [15:0] i_step, i_acc;
  logic signed [9:0]  integ_r, integ_nxt;
  logic signed [11:0] sum_c;
  logic [10:0]        sum_abs;
  logic [9:0]         mag_c;
  out_beat_t          out_nxt, out_r;

  always_comb begin
    pq = div3(s1_pm_r);
    dq = div3(s1_dm_r);
    iq = div3(s1_im_r);

    p_mag  = (pq > {5'b0, P_LIMIT}) ? P_LIMIT : pq[9:0];
    d_mag  = (dq > {8'b0, D_LIMIT}) ? D_LIMIT : dq[6:0];
    p_term = s1_eneg_r ? -signed'({2'b0, p_mag}) : signed'({2'b0, p_mag});
    d_term = s1_dneg_r ? -signed'({5'b0, d_mag}) : signed'({5'b0, d_mag});

    // Accumulate, clear at rest, clamp
    i_step = s1_eneg_r ? -signed'({1'b0, iq}) : signed'({1'b0, iq});
    i_acc  = 16'(integ_r) + i_step;
    if (s1_clr_r) begin
      integ_nxt = '0;
    end else if (i_acc > I_LIMIT) begin
      integ_nxt = I_LIMIT[9:0];
    end else if (i_acc < -I_LIMIT) begin
      integ_nxt = 10'(-I_LIMIT);
    end else begin
      integ_nxt = i_acc[9:0];
    end

    sum_c   = p_term + d_term + 12'(integ_nxt);
    sum_abs = sum_c[11] ? 11'(-sum_c) : sum_c[10:0];
    mag_c   = (sum_abs > {1'b0, DUTY_FULL}) ? DUTY_FULL : sum_abs[9:0];

    out_nxt.pad            = 1'b0;
    out_nxt.measured_speed = s1_spd_r;
    out_nxt.speed_error    = s1_err_r;
    out_nxt.drive_sum      = sum_c;
    out_nxt.drive_forward  = !sum_c[11];
    out_nxt.pwm_duty       = DUTY_FULL - mag_c;
  end

  // ------------------------------------------------------------------
  // Control registers and state
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r     <= 1'b0;
      s1_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      prev_err_r <= '0;
      integ_r    <= '0;
    end else begin
      if (s0_rdy) begin
        s0_v_r <= in_tvalid;
      end
      if (s1_rdy) begin
        s1_v_r <= s0_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s1_v_r;
      end
      // Last error follows ticks in arrival order
      if (s0_adv) begin
        prev_err_r <= err_c;
      end
      if (s1_adv) begin
        integ_r <= integ_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && s0_rdy) begin
      s0_cnt_r <= in_tdata[15:0];
    end
    if (s0_adv) begin
      s1_pm_r   <= {8'b0, err_abs} * {8'b0, p_gain_r};
      s1_im_r   <= {8'b0, err_abs} * {8'b0, i_gain_r};
      s1_dm_r   <= {8'b0, derr_abs} * {8'b0, d_gain_r};
      s1_eneg_r <= err_neg;
      s1_dneg_r <= derr_neg;
      s1_clr_r  <= (speed_target_r == 8'sd0) && (spd_c == 8'sd0);
      s1_err_r  <= err_c;
      s1_spd_r  <= spd_c;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `WSPP_ASSERT(a_integ_range, (integ_r <= 10'sd500) && (integ_r >= -10'sd500), "integral out of range")
  `WSPP_ASSERT_NEXT(a_integ_clear, s1_adv && s1_clr_r, integ_r == 10'sd0, "integral not cleared at rest")
  `WSPP_ASSERT(a_dir_sign, !out_v_r || (out_r.drive_forward == !out_r.drive_sum[11]), "direction disagrees with sum")
  `WSPP_ASSERT(a_duty_range, !out_v_r || (out_r.pwm_duty <= DUTY_FULL), "duty above full scale")

endmodule

// ===== verif/duty_checker.sv =====
// Checker for the wheel speed controller: predicts each result beat and compares it.
`timescale 1ns / 100ps

module duty_checker
  import wspp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [7:0]            cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [15:0] position_count
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,   // [9:0] pwm_duty, [10] drive_forward,
                                             // [22:11] drive_sum, [30:23] speed_error,
                                             // [38:31] measured_speed, [39] zero
  output int                    ticks_open,
  output int                    fault_count
);

  logic [7:0]        kp, ki, kd;
  logic signed [7:0] target;
  logic signed [7:0] prev_err;
  logic signed [9:0] integ;
  out_beat_t         duty_q[$];
  int                beat_no;

  function automatic int clamp_to(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Work out one control tick and advance the error history and integral.
  function automatic out_beat_t next_duty(input logic [15:0] raw);
    int        cnt, spd, err, p_term, d_term, i_acc, sum, mag;
    out_beat_t b;
    cnt = raw;
    if (cnt >= 'h8400) cnt = 'h83FF;
    if (cnt <= 'h7C00) cnt = 'h7C01;
    if (cnt >= 'h8000) spd = (cnt - 'h8000) / 4;
    else spd = -(('h8000 - cnt) / 4);
    spd = clamp_to(spd, 127);
    err = spd - int'(target);
    if (err > 127) err = 119;
    else if (err < -128) err = -119;
    p_term = clamp_to(err * int'(kp) / 3, 900);
    d_term = clamp_to(int'(kd) * (err - int'(prev_err)) / 3, 127);
    i_acc  = int'(integ) + int'(ki) * err / 3;
    if (target == 0 && spd == 0) i_acc = 0;
    i_acc  = clamp_to(i_acc, 500);
    sum    = p_term + d_term + i_acc;
    mag    = (sum >= 0) ? sum : -sum;
    if (mag > 1020) mag = 1020;
    b.pad            = 1'b0;
    b.pwm_duty       = 10'(1020 - mag);
    b.drive_forward  = (sum >= 0);
    b.drive_sum      = sum[11:0];
    b.speed_error    = err[7:0];
    b.measured_speed = spd[7:0];
    prev_err = err[7:0];
    integ    = i_acc[9:0];
    return b;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fault_count++;
    $display("mismatch at result beat %0d, %s: got %0d, want %0d", beat_no, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    out_beat_t got, want;
    if (!rst_n) begin
      kp          = P_GAIN_RST;
      ki          = I_GAIN_RST;
      kd          = D_GAIN_RST;
      target      = '0;
      prev_err    = '0;
      integ       = '0;
      beat_no     = 0;
      fault_count = 0;
      duty_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          REG_P_GAIN:       kp = cfg_wdata;
          REG_I_GAIN:       ki = cfg_wdata;
          REG_D_GAIN:       kd = cfg_wdata;
          REG_SPEED_TARGET: target = cfg_wdata;
          default: ;
        endcase
      end
      // Pop before push: a result can never leave in the cycle its tick arrives.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (duty_q.size() == 0) begin
          report_mismatch("beat with nothing pending", int'(out_tdata[31:0]), 0);
        end else begin
          want = duty_q.pop_front();
          if (got.pwm_duty != want.pwm_duty)
            report_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
          if (got.drive_forward != want.drive_forward)
            report_mismatch("drive_forward", got.drive_forward, want.drive_forward);
          if (got.drive_sum != want.drive_sum)
            report_mismatch("drive_sum", int'(got.drive_sum), int'(want.drive_sum));
          if (got.speed_error != want.speed_error)
            report_mismatch("speed_error", int'(got.speed_error), int'(want.speed_error));
          if (got.measured_speed != want.measured_speed)
            report_mismatch("measured_speed", int'(got.measured_speed),
                            int'(want.measured_speed));
          if (got.pad !== 1'b0)
            report_mismatch("zero fill bit", got.pad, 0);
        end
        beat_no++;
      end
      if (in_tvalid && in_tready)
        duty_q.push_back(next_duty(in_tdata));
    end
    ticks_open <= duty_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the wheel speed controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import wspp_pkg::*;

  localparam int STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int PHASES      = 9;
  localparam int PHASE_TICKS = 100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_addr;
  logic [7:0]            cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int ticks_open;
  int fault_count;
  int idle_cycles;
  bit quiet;       // no idling on either side
  int hold_req;    // bump to ask the receiver for one long hold-off

  // Corner counts run with the reset gains: window edges, rounding around the
  // center, speed saturation and the zero speed case that clears the integral.
  logic [15:0] corner_counts [16] = '{
    16'h8000, 16'h0000, 16'hFFFF, 16'h7C00, 16'h7C01, 16'h7C02, 16'h83FF, 16'h8400,
    16'h8001, 16'h8004, 16'h7FFF, 16'h7FFC, 16'h7FFB, 16'h8200, 16'h7E00, 16'h8000
  };

  wheel_speed_pid_pwm DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  duty_checker CHK (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .ticks_open  (ticks_open),
    .fault_count (fault_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Offer one tick beat and hold it until the block takes it. An idle burst
  // may come first; valid stays high straight into the next beat otherwise.
  task automatic send_tick(input logic [15:0] raw);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
  endtask

  // One register write, then a quiet cycle so the enable never toggles twice
  // in one step.
  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_gains(input logic [7:0] p, input logic [7:0] i, input logic [7:0] d,
                            input logic [7:0] tgt);
    write_reg(REG_P_GAIN, p);
    write_reg(REG_I_GAIN, i);
    write_reg(REG_D_GAIN, d);
    write_reg(REG_SPEED_TARGET, tgt);
  endtask

  // Drop valid and wait until every predicted result has come back, then give
  // the pipeline its latency to go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ticks_open != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly counts inside the clamp window, many near the center where the
  // integral clear and small errors live, some anywhere in 16 bits.
  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom_range(0, 16'hFFFF));
      2, 3, 4: return 16'($urandom_range(16'h7FE0, 16'h8020));
      default: return 16'($urandom_range(16'h7B80, 16'h8480));
    endcase
  endfunction

  // Receiver: ready in random stretches, short random stalls, and one long
  // hold-off on request, counted here while the sender keeps going.
  initial begin : receiver
    int hold_done;
    hold_done  = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [7:0] tgt;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    quiet      = 1'b0;
    hold_req   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corners with the gains and target as they come out of reset.
    foreach (corner_counts[k]) send_tick(corner_counts[k]);

    // Full gains, lowest target: positive error overflow.
    settle();
    load_gains(8'hFF, 8'hFF, 8'hFF, 8'h80);
    send_tick(16'hFFFF);
    send_tick(16'h8000);
    send_tick(16'h81FC);

    // Highest target: negative overflow, and the -128 error that just fits.
    settle();
    write_reg(REG_SPEED_TARGET, 8'h7F);
    send_tick(16'h0000);
    send_tick(16'h7FFC);
    send_tick(16'h7FF8);

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      tgt = ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      case (p)
        0:       load_gains(8'hFF, 8'hFF, 8'hFF, 8'h80);
        1:       load_gains(8'h00, 8'h00, 8'h00, 8'h7F);
        2:       load_gains(P_GAIN_RST, I_GAIN_RST, D_GAIN_RST, 8'h00);
        default: load_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), tgt);
      endcase
      quiet = (p == PHASES - 1);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        // Fill the pipeline against a stalled receiver.
        if (p == 3 && n == 30) hold_req++;
        // Pause the sender until everything in flight has drained.
        if (p == 4 && n == 50) settle();
        send_tick(pick_count());
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
